FILE: rtl/core/extended_gcd_bezout_macros.svh
// Assertion macros for the extended gcd block.
// Needs a signal clk and a signal rst in the scope where a macro is used.
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// Same-cycle implication, off during reset.
`define EBZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define EBZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ebz_pkg.sv
// Shared types and constants of the extended gcd block.
// No dependencies; used by the controller, the datapath and the top level.
package ebz_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new operand pair
    logic start;    // set up one truncating division
    logic step;     // one restoring division bit
    logic update;   // fold the quotient into remainders and coefficients
    logic publish;  // copy the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_zero;  // current remainder is zero, sequence done
    logic div_last;  // the step in progress is the last quotient bit
  } sts_t;

endpackage

FILE: rtl/core/ebz_ctrl.sv
// Controller of the extended gcd block: sequences load, division steps,
// coefficient updates and the output handshake. Uses ebz_pkg.
module ebz_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ebz_pkg::sts_t sts,
  output ebz_pkg::cmd_t cmd
);
  import ebz_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cur_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_CHECK;
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/ebz_dp.sv
// Datapath of the extended gcd block: remainder and coefficient registers,
// a bit-serial restoring divider and the output register. Uses ebz_pkg.
module ebz_dp #(
  parameter int DATA_WIDTH = ebz_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ebz_pkg::cmd_t         cmd,
  output ebz_pkg::sts_t         sts,
  input  logic [DATA_WIDTH-1:0] value_a,
  input  logic [DATA_WIDTH-1:0] value_b,
  output logic [DATA_WIDTH-1:0] coef_x,
  output logic [DATA_WIDTH-1:0] coef_y,
  output logic [DATA_WIDTH-1:0] divisor
);
  import ebz_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] prev_r, cur_r, prev_x, cur_x, prev_y, cur_y;
  logic [DATA_WIDTH-1:0] num_sh, den, rem, acc_x, acc_y;
  logic                  num_neg, quo_neg;
  logic [CNT_W-1:0]      cnt;

  logic [DATA_WIDTH-1:0] prev_mag, cur_mag;
  logic [DATA_WIDTH:0]   rem_sh;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next, rem_signed, x_next, y_next;

  assign prev_mag = prev_r[DATA_WIDTH-1] ? (~prev_r + 1'b1) : prev_r;
  assign cur_mag  = cur_r[DATA_WIDTH-1]  ? (~cur_r + 1'b1)  : cur_r;

  // restoring division, one quotient bit per cycle, most significant first
  assign rem_sh   = {rem, num_sh[DATA_WIDTH-1]};
  assign fits     = (rem_sh >= {1'b0, den});
  assign rem_next = fits ? DATA_WIDTH'(rem_sh - {1'b0, den}) : rem_sh[DATA_WIDTH-1:0];

  // remainder takes the dividend's sign; acc holds |q| times the coefficient
  assign rem_signed = num_neg ? (~rem + 1'b1) : rem;
  assign x_next     = quo_neg ? (prev_x + acc_x) : (prev_x - acc_x);
  assign y_next     = quo_neg ? (prev_y + acc_y) : (prev_y - acc_y);

  assign sts.cur_zero = (cur_r == '0);
  assign sts.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r <= value_a;
      cur_r  <= value_b;
      prev_x <= DATA_WIDTH'(1);
      cur_x  <= '0;
      prev_y <= '0;
      cur_y  <= DATA_WIDTH'(1);
    end else if (cmd.update) begin
      prev_r <= cur_r;
      cur_r  <= rem_signed;
      prev_x <= cur_x;
      cur_x  <= x_next;
      prev_y <= cur_y;
      cur_y  <= y_next;
    end

    if (cmd.start) begin
      num_sh  <= prev_mag;
      den     <= cur_mag;
      rem     <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      num_neg <= prev_r[DATA_WIDTH-1];
      quo_neg <= prev_r[DATA_WIDTH-1] ^ cur_r[DATA_WIDTH-1];
    end else if (cmd.step) begin
      num_sh <= num_sh << 1;
      rem    <= rem_next;
      // Horner form of |q| * coef, wrapping at the word width
      acc_x  <= (acc_x << 1) + (fits ? cur_x : '0);
      acc_y  <= (acc_y << 1) + (fits ? cur_y : '0);
    end

    if (cmd.publish) begin
      coef_x  <= prev_x;
      coef_y  <= prev_y;
      divisor <= prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= CNT_LAST;
    end else if (cmd.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

FILE: rtl/core/extended_gcd_bezout.sv
// Extended Euclidean algorithm: Bezout coefficients and last remainder.
// Depends on ebz_pkg, ebz_ctrl, ebz_dp and extended_gcd_bezout_macros.svh.
//
// Input channel: value_a, value_b with in_valid / in_stall. One beat in gives
// one beat out on coef_x, coef_y, divisor with out_valid / out_stall, such that
// a*coef_x + b*coef_y == divisor (truncating quotients, wrapping arithmetic).
// When value_b is zero the result is (1, 0, value_a).
// Each of the k remainder steps (up to about 46 at 32 bits) sets up one
// truncating division, runs the one-bit restoring divider for DATA_WIDTH
// quotient bits and then updates remainders and coefficients. One item at a
// time: in_stall is high from acceptance until the result moves to the output
// register. The output register frees the input side, so a new beat may be
// taken while a result waits; if the receiver still stalls when the next
// result is done, that result holds inside until the register is taken.
// Reset (synchronous, active high) drops any item in flight and clears
// out_valid; the block keeps no state between items.
module extended_gcd_bezout #(
  parameter int DATA_WIDTH = ebz_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] value_a,
  input  logic [DATA_WIDTH-1:0] value_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] coef_x,
  output logic [DATA_WIDTH-1:0] coef_y,
  output logic [DATA_WIDTH-1:0] divisor
);
  import ebz_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ebz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebz_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .value_a (value_a),
    .value_b (value_b),
    .coef_x  (coef_x),
    .coef_y  (coef_y),
    .divisor (divisor)
  );

`include "extended_gcd_bezout_macros.svh"

  `EBZ_ASSERT_NOW(a_no_overwrite, cmd.publish, !(out_valid && out_stall), "publish while stalled")
  `EBZ_ASSERT_NOW(a_busy_stalls, cmd.step || cmd.update || cmd.start, in_stall, "open while busy")
  `EBZ_ASSERT_NOW(a_update_after_div, cmd.update, $past(cmd.step && sts.div_last), "early update")
  `EBZ_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid && !in_stall, "no beat after publish")

endmodule

FILE: dv/tb_top.sv
// Testbench for extended_gcd_bezout: a directed table of operand pairs, then random pairs.
// Every result beat is checked against a hand-written answer or a Bezout predictor that uses truncating division.
// Depends on ebz_pkg and the RTL of the block.
module tb_top;
  import ebz_pkg::*;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int RANDOM_PAIRS = 400;
  localparam int STALL_PCT    = 23;
  localparam int HANG_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 2000;
  localparam int REPORT_MAX   = 10;

  typedef logic [DW-1:0] word_t;
  typedef struct packed {
    word_t x;
    word_t y;
    word_t g;
  } bezout_t;
  typedef struct packed {
    word_t   a;
    word_t   b;
    bit      known;
    bezout_t res;
  } pair_row_t;

  localparam word_t POS_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam word_t NEG_MAX  = {1'b1, {(DW-2){1'b0}}, 1'b1};
  localparam word_t MOST_NEG = {1'b1, {(DW-1){1'b0}}};

  // Rows marked known carry the answer by hand; the rest go through the predictor.
  localparam pair_row_t PAIR_TABLE [25] = '{
    '{0,           0,           1'b1, '{1, 0, 0}},
    '{5,           0,           1'b1, '{1, 0, 5}},
    '{-7,          0,           1'b1, '{1, 0, -7}},
    '{POS_MAX,     0,           1'b1, '{1, 0, POS_MAX}},
    '{NEG_MAX,     0,           1'b1, '{1, 0, NEG_MAX}},
    '{0,           5,           1'b1, '{0, 1, 5}},
    '{POS_MAX,     POS_MAX,     1'b1, '{0, 1, POS_MAX}},
    '{NEG_MAX,     NEG_MAX,     1'b1, '{0, 1, NEG_MAX}},
    '{POS_MAX,     1,           1'b1, '{0, 1, 1}},
    '{POS_MAX,     NEG_MAX,     1'b1, '{0, 1, NEG_MAX}},
    '{NEG_MAX,     1,           1'b1, '{0, 1, 1}},
    '{-1,          -1,          1'b1, '{0, 1, -1}},
    '{1,           POS_MAX,     1'b0, '{0, 0, 0}},
    '{1836311903,  1134903170,  1'b0, '{0, 0, 0}},
    '{-1836311903, 1134903170,  1'b0, '{0, 0, 0}},
    '{1134903170,  -1836311903, 1'b0, '{0, 0, 0}},
    '{-1836311903, -1134903170, 1'b0, '{0, 0, 0}},
    '{POS_MAX,     POS_MAX - 1, 1'b0, '{0, 0, 0}},
    '{12,          18,          1'b0, '{0, 0, 0}},
    '{-12,         18,          1'b0, '{0, 0, 0}},
    '{12,          -18,         1'b0, '{0, 0, 0}},
    '{-12,         -18,         1'b0, '{0, 0, 0}},
    '{240,         46,          1'b0, '{0, 0, 0}},
    '{32'h5555_5555, 32'h2AAA_AAAA, 1'b0, '{0, 0, 0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{0, 0, 0}}
  };

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  word_t value_a   = '0;
  word_t value_b   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t coef_x;
  word_t coef_y;
  word_t divisor;

  bit      calm = 1'b0;
  bezout_t bezout_q [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;

  extended_gcd_bezout #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value_a  (value_a),
    .value_b  (value_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coef_x   (coef_x),
    .coef_y   (coef_y),
    .divisor  (divisor)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Remainder sequence with quotients truncated toward zero, all arithmetic wrapping.
  function automatic bezout_t solve_bezout(word_t a, word_t b);
    word_t   r0, r1, x0, x1, y0, y1;
    word_t   nm, dm, qm, rm, q, rem, nx, ny;
    bezout_t res;
    r0 = a;
    r1 = b;
    x0 = 1;
    x1 = 0;
    y0 = 0;
    y1 = 1;
    while (r1 != 0) begin
      nm  = r0[DW-1] ? -r0 : r0;
      dm  = r1[DW-1] ? -r1 : r1;
      qm  = nm / dm;
      rm  = nm % dm;
      q   = (r0[DW-1] != r1[DW-1]) ? -qm : qm;
      rem = r0[DW-1] ? -rm : rm;
      nx  = x0 - q * x1;
      ny  = y0 - q * y1;
      r0  = r1;
      r1  = rem;
      x0  = x1;
      x1  = nx;
      y0  = y1;
      y1  = ny;
    end
    res.x = x0;
    res.y = y0;
    res.g = r0;
    return res;
  endfunction

  function automatic word_t with_sign(word_t mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Full range except the most negative value, which the operands exclude.
  function automatic word_t any_operand();
    word_t w;
    w = $urandom;
    return (w == MOST_NEG) ? NEG_MAX : w;
  endfunction

  function automatic word_t edge_operand();
    case ($urandom_range(0, 4))
      0: return POS_MAX;
      1: return NEG_MAX;
      2: return 1;
      3: return -1;
      default: return any_operand();
    endcase
  endfunction

  function automatic void pick_pair(output word_t a, output word_t b);
    int    kind;
    int    k;
    word_t g, f0, f1, t;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      a = any_operand();
      b = any_operand();
    end else if (kind < 60) begin
      a = with_sign($urandom_range(0, 1000));
      b = with_sign($urandom_range(0, 1000));
    end else if (kind < 72) begin
      // shared factor, so the gcd is large
      g = $urandom_range(1, 65535);
      a = with_sign(g * $urandom_range(0, 32767));
      b = with_sign(g * $urandom_range(0, 32767));
    end else if (kind < 84) begin
      // consecutive Fibonacci numbers give the longest remainder chains
      f0 = 0;
      f1 = 1;
      k  = $urandom_range(1, 45);
      repeat (k) begin
        t  = f0 + f1;
        f0 = f1;
        f1 = t;
      end
      a = with_sign(f1);
      b = with_sign(f0);
    end else if (kind < 92) begin
      a = any_operand();
      b = '0;
      if ($urandom_range(0, 3) == 0) begin
        b = a;
        a = '0;
      end
    end else begin
      a = edge_operand();
      b = edge_operand();
    end
  endfunction

  // Present one beat, hold it until taken, then queue its answer.
  task automatic offer(input word_t a, input word_t b, input bezout_t want);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value_a  <= a;
    value_b  <= b;
    do @(posedge clk); while (in_stall);
    bezout_q.insert(bezout_q.size(), want);
  endtask

  always @(posedge clk) begin : result_check
    bezout_t want;
    if (rst) begin
      out_stall    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (bezout_q.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected result beat: x=%0d y=%0d g=%0d",
                     $signed(coef_x), $signed(coef_y), $signed(divisor));
          end
          mismatches++;
        end else begin
          want = bezout_q.pop_front();
          if (coef_x !== want.x || coef_y !== want.y || divisor !== want.g) begin
            if (mismatches < REPORT_MAX) begin
              $display("mismatch: expected x=%0d y=%0d g=%0d, actual x=%0d y=%0d g=%0d",
                       $signed(want.x), $signed(want.y), $signed(want.g),
                       $signed(coef_x), $signed(coef_y), $signed(divisor));
            end
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    word_t a, b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (PAIR_TABLE[i]) begin
      offer(PAIR_TABLE[i].a, PAIR_TABLE[i].b,
            PAIR_TABLE[i].known ? PAIR_TABLE[i].res
                                : solve_bezout(PAIR_TABLE[i].a, PAIR_TABLE[i].b));
    end
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == 60) begin
        // drain the block before offering more
        in_valid <= 1'b0;
        do @(posedge clk); while (bezout_q.size() != 0);
      end
      calm <= (n >= 150 && n < 230);
      pick_pair(a, b);
      offer(a, b, solve_bezout(a, b));
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (bezout_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
